// ===== src/schedule_move_delta_scoring_unit_defines.svh =====
// Assertion macros for the scoring unit
`ifndef SCHEDULE_MOVE_DELTA_SCORING_UNIT_DEFINES_SVH
`define SCHEDULE_MOVE_DELTA_SCORING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SMDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SMDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SMDS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SMDS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== src/smds_pkg.sv =====
package smds_pkg;

  localparam int INDEX_BITS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int FRAC_BITS   = 12;
  localparam int SCORE_W     = 32;

  // digit-serial datapath
  localparam int DIGIT       = 4;
  localparam int LANE_OPS    = 4;
  localparam int SUM_W       = DIGIT + 2;
  localparam int DW_RAW      = ((TIME_BITS > SCORE_W - 1) ? TIME_BITS : SCORE_W - 1) + 4;
  localparam int DW          = ((DW_RAW + DIGIT - 1) / DIGIT) * DIGIT;
  localparam int NDIG        = DW / DIGIT;
  localparam int CNT_W       = $clog2(NDIG);

  // reciprocal: floor(2^RECIP_SHIFT / mag)
  localparam int RECIP_SHIFT = 2 * FRAC_BITS;
  localparam int QW          = RECIP_SHIFT + 1;
  localparam int RW          = RECIP_SHIFT + 2;
  localparam int RCNT_W      = $clog2(QW);

  localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W - 1){1'b1}}};
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W - 1){1'b0}}};

  localparam logic OP_SWAP = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] mag;
  } recip_req_t;

  typedef struct packed {
    logic               done;
    logic [SCORE_W-1:0] q;
  } recip_rsp_t;

endpackage

// ===== src/smds_if.sv =====
interface smds_in_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic                             last;
  logic [smds_pkg::INDEX_BITS-1:0]  origin_task;
  logic [smds_pkg::INDEX_BITS-1:0]  target;
  logic                             same_machine;
  logic [smds_pkg::TIME_BITS-1:0]   time_a_old;
  logic [smds_pkg::TIME_BITS-1:0]   time_b_old;
  logic [smds_pkg::TIME_BITS-1:0]   exec_x_on_a;
  logic [smds_pkg::TIME_BITS-1:0]   exec_y_on_a;
  logic [smds_pkg::TIME_BITS-1:0]   exec_y_on_b;
  logic [smds_pkg::TIME_BITS-1:0]   exec_x_on_b;
  logic [smds_pkg::TIME_BITS-1:0]   makespan;

  modport source (
    output valid, operation, last, origin_task, target, same_machine,
           time_a_old, time_b_old, exec_x_on_a, exec_y_on_a, exec_y_on_b,
           exec_x_on_b, makespan,
    input  ready
  );

  modport sink (
    input  valid, operation, last, origin_task, target, same_machine,
           time_a_old, time_b_old, exec_x_on_a, exec_y_on_a, exec_y_on_b,
           exec_x_on_b, makespan,
    output ready
  );
endinterface

interface smds_out_if;
  logic                               valid;
  logic                               ready;
  logic                               best_kind;
  logic [smds_pkg::INDEX_BITS-1:0]    best_origin;
  logic [smds_pkg::INDEX_BITS-1:0]    best_target;
  logic signed [smds_pkg::SCORE_W-1:0] best_score;

  modport source (
    output valid, best_kind, best_origin, best_target, best_score,
    input  ready
  );

  modport sink (
    input  valid, best_kind, best_origin, best_target, best_score,
    output ready
  );
endinterface

// ===== src/schedule_move_delta_scoring_unit.sv =====
// Schedule move-delta scoring unit.
// Input channel in_i carries one candidate word (swap or move) with the
// machine times, execution times and makespan; output channel out_o carries
// the best candidate of a run, sent once for the word marked last.
// The sums are digit serial, four bits a cycle, over a 36-bit word.
// Per word: accept, the first pass (all sums and compares), pick the score
// form, a wait on the shared radix-2 reciprocal unit when the form needs
// one, a load step, the second pass, then saturate and keep the best.
// in_i.ready is high only between words. A result sits in an output
// register; the next word is taken while it waits, and only a later word
// marked last holds in its final cycle until out_o.ready frees the register.
// Reset clears the run, the held best (score 0) and the output valid.
`include "schedule_move_delta_scoring_unit_defines.svh"

module schedule_move_delta_scoring_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  smds_in_if.sink      in_i,
  smds_out_if.source   out_o
);

  localparam int DW      = smds_pkg::DW;
  localparam int DIGIT   = smds_pkg::DIGIT;
  localparam int SCORE_W = smds_pkg::SCORE_W;
  localparam int IW      = smds_pkg::INDEX_BITS;

  localparam int LN_AOV    = 0;
  localparam int LN_BOV    = 1;
  localparam int LN_DA     = 2;
  localparam int LN_DB     = 3;
  localparam int LN_DAB    = 4;
  localparam int LN_ACRIT  = 5;
  localparam int LN_BCRIT  = 6;
  localparam int LN_MOV    = 7;
  localparam int LN_DXB    = 8;
  localparam int LN_NDA    = 9;
  localparam int LN_NDB    = 10;
  localparam int LN_NDAB   = 11;
  localparam int LN_NDXB   = 12;
  localparam int LN_NXA    = 13;
  localparam int LN_XB     = 14;
  localparam int NUM_LANES = 15;

  localparam logic [DW-1:0]    ONE_Q = DW'(1) << smds_pkg::FRAC_BITS;
  localparam logic [DIGIT-1:0] DZ    = '0;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_PASS1    = 7'b0000010,
    ST_CLASSIFY = 7'b0000100,
    ST_DIV      = 7'b0001000,
    ST_LOAD2    = 7'b0010000,
    ST_PASS2    = 7'b0100000,
    ST_DECIDE   = 7'b1000000
  } state_e;

  typedef enum logic [2:0] {
    SRC_ZERO, SRC_AOV, SRC_BOV, SRC_DA, SRC_DB, SRC_MOV, SRC_NXA, SRC_RECIP
  } src_e;

  state_e state_q, state_d;
  logic [smds_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic accept;
  logic last_digit;

  logic kind_q, last_q, same_q;
  logic [IW-1:0] origin_q, target_q;
  logic [DW-1:0] ta_q, tb_q, xa_q, ya_q, yb_q, xb_q, m_q, one_q;

  logic [DIGIT-1:0] d_ta, d_tb, d_xa, d_ya, d_yb, d_xb, d_m, d_one;
  logic [smds_pkg::LANE_OPS-1:0][DIGIT-1:0] lane_dig [NUM_LANES];
  logic [1:0]    lane_cin [NUM_LANES];
  logic [DW-1:0] lane_res [NUM_LANES];

  logic aov, bov, acrit, bcrit, mov;
  src_e sel_a_d, sel_b_d, sel_a_q, sel_b_q;
  logic neg_d, neg_q;
  logic recip_go;
  logic [DW-1:0] recip_mag;
  smds_pkg::recip_req_t recip_req;
  smds_pkg::recip_rsp_t recip_rsp;

  logic [DW-1:0] opa_q, opb_q, opa_val, opb_val;
  logic inv_a_q, inv_b_q, inv_a_val, inv_b_val;
  logic [smds_pkg::LANE_OPS-1:0][DIGIT-1:0] p2_dig;
  logic [1:0]    p2_cin;
  logic [DW-1:0] score_sum;

  logic fits;
  logic signed [SCORE_W-1:0] sat_score;
  logic take, out_free, commit;

  logic run_open_q;
  logic held_kind_q;
  logic [IW-1:0] held_origin_q, held_target_q;
  logic signed [SCORE_W-1:0] held_score_q;
  logic nxt_kind;
  logic [IW-1:0] nxt_origin, nxt_target;
  logic signed [SCORE_W-1:0] nxt_score;

  logic out_valid_q, out_kind_q;
  logic [IW-1:0] out_origin_q, out_target_q;
  logic signed [SCORE_W-1:0] out_score_q;

  // ---------------------------------------------------------------- control
  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign last_digit = (cnt_q == smds_pkg::CNT_W'(smds_pkg::NDIG - 1));
  assign out_free   = !out_valid_q || out_o.ready;
  assign commit     = (state_q == ST_DECIDE) && (!last_q || out_free);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          state_d = ST_PASS1;
        end
      end
      ST_PASS1: begin
        cnt_d = cnt_q + 1'b1;
        if (last_digit) begin
          cnt_d   = '0;
          state_d = ST_CLASSIFY;
        end
      end
      ST_CLASSIFY: begin
        state_d = recip_go ? ST_DIV : ST_LOAD2;
      end
      ST_DIV: begin
        if (recip_rsp.done) begin
          state_d = ST_LOAD2;
        end
      end
      ST_LOAD2: begin
        cnt_d   = '0;
        state_d = ST_PASS2;
      end
      ST_PASS2: begin
        cnt_d = cnt_q + 1'b1;
        if (last_digit) begin
          cnt_d   = '0;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // ------------------------------------------------------ operand shifters
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q   <= in_i.operation;
      last_q   <= in_i.last;
      same_q   <= in_i.same_machine;
      origin_q <= in_i.origin_task;
      target_q <= in_i.target;
      ta_q     <= DW'(in_i.time_a_old);
      tb_q     <= DW'(in_i.time_b_old);
      xa_q     <= DW'(in_i.exec_x_on_a);
      ya_q     <= DW'(in_i.exec_y_on_a);
      yb_q     <= DW'(in_i.exec_y_on_b);
      xb_q     <= DW'(in_i.exec_x_on_b);
      m_q      <= DW'(in_i.makespan);
      one_q    <= ONE_Q;
    end else if (state_q == ST_PASS1) begin
      ta_q  <= ta_q  >> DIGIT;
      tb_q  <= tb_q  >> DIGIT;
      xa_q  <= xa_q  >> DIGIT;
      ya_q  <= ya_q  >> DIGIT;
      yb_q  <= yb_q  >> DIGIT;
      xb_q  <= xb_q  >> DIGIT;
      m_q   <= m_q   >> DIGIT;
      one_q <= one_q >> DIGIT;
    end
  end

  assign d_ta  = ta_q[DIGIT-1:0];
  assign d_tb  = tb_q[DIGIT-1:0];
  assign d_xa  = xa_q[DIGIT-1:0];
  assign d_ya  = ya_q[DIGIT-1:0];
  assign d_yb  = yb_q[DIGIT-1:0];
  assign d_xb  = xb_q[DIGIT-1:0];
  assign d_m   = m_q[DIGIT-1:0];
  assign d_one = one_q[DIGIT-1:0];

  // first pass: every sum the score can need, subtraction as ~x + 1
  always_comb begin
    lane_dig[LN_AOV]   = {d_ta, ~d_xa, d_ya, ~d_m};
    lane_cin[LN_AOV]   = 2'd2;
    lane_dig[LN_BOV]   = {d_tb, ~d_yb, d_xb, ~d_m};
    lane_cin[LN_BOV]   = 2'd2;
    lane_dig[LN_DA]    = {d_ya, ~d_xa, DZ, DZ};
    lane_cin[LN_DA]    = 2'd1;
    lane_dig[LN_DB]    = {d_xb, ~d_yb, DZ, DZ};
    lane_cin[LN_DB]    = 2'd1;
    lane_dig[LN_DAB]   = {d_ya, ~d_xa, d_xb, ~d_yb};
    lane_cin[LN_DAB]   = 2'd2;
    lane_dig[LN_ACRIT] = {d_ta, d_one, ~d_m, DZ};
    lane_cin[LN_ACRIT] = 2'd1;
    lane_dig[LN_BCRIT] = {d_tb, d_one, ~d_m, DZ};
    lane_cin[LN_BCRIT] = 2'd1;
    lane_dig[LN_MOV]   = {d_tb, d_xb, ~d_m, DZ};
    lane_cin[LN_MOV]   = 2'd1;
    lane_dig[LN_DXB]   = {d_xb, ~d_xa, DZ, DZ};
    lane_cin[LN_DXB]   = 2'd1;
    lane_dig[LN_NDA]   = {d_xa, ~d_ya, DZ, DZ};
    lane_cin[LN_NDA]   = 2'd1;
    lane_dig[LN_NDB]   = {d_yb, ~d_xb, DZ, DZ};
    lane_cin[LN_NDB]   = 2'd1;
    lane_dig[LN_NDAB]  = {d_xa, ~d_ya, d_yb, ~d_xb};
    lane_cin[LN_NDAB]  = 2'd2;
    lane_dig[LN_NDXB]  = {d_xa, ~d_xb, DZ, DZ};
    lane_cin[LN_NDXB]  = 2'd1;
    lane_dig[LN_NXA]   = {~d_xa, DZ, DZ, DZ};
    lane_cin[LN_NXA]   = 2'd1;
    lane_dig[LN_XB]    = {d_xb, DZ, DZ, DZ};
    lane_cin[LN_XB]    = 2'd0;
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    smds_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clear_i (accept),
      .shift_i (state_q == ST_PASS1),
      .cin_i   (lane_cin[l]),
      .dig_i   (lane_dig[l]),
      .res_o   (lane_res[l])
    );
  end

  // ------------------------------------------------------- score form
  assign aov   = !lane_res[LN_AOV][DW-1] && (|lane_res[LN_AOV]);
  assign bov   = !lane_res[LN_BOV][DW-1] && (|lane_res[LN_BOV]);
  assign mov   = !lane_res[LN_MOV][DW-1] && (|lane_res[LN_MOV]);
  assign acrit = !lane_res[LN_ACRIT][DW-1];
  assign bcrit = !lane_res[LN_BCRIT][DW-1];

  always_comb begin
    sel_a_d   = SRC_ZERO;
    sel_b_d   = SRC_ZERO;
    neg_d     = 1'b0;
    recip_go  = 1'b0;
    recip_mag = lane_res[LN_XB];
    unique case (kind_q)
      smds_pkg::OP_SWAP: begin
        if (same_q) begin
          sel_a_d = SRC_ZERO;
        end else if (aov || bov) begin
          sel_a_d = aov ? SRC_AOV : SRC_ZERO;
          sel_b_d = bov ? SRC_BOV : SRC_ZERO;
        end else if (acrit || bcrit) begin
          sel_a_d = acrit ? SRC_DA : SRC_RECIP;
          sel_b_d = bcrit ? SRC_DB : SRC_RECIP;
          if (!acrit) begin
            recip_go  = 1'b1;
            neg_d     = lane_res[LN_DA][DW-1];
            recip_mag = neg_d ? lane_res[LN_NDA] : lane_res[LN_DA];
          end else if (!bcrit) begin
            recip_go  = 1'b1;
            neg_d     = lane_res[LN_DB][DW-1];
            recip_mag = neg_d ? lane_res[LN_NDB] : lane_res[LN_DB];
          end
        end else begin
          sel_a_d   = SRC_RECIP;
          recip_go  = 1'b1;
          neg_d     = lane_res[LN_DAB][DW-1];
          recip_mag = neg_d ? lane_res[LN_NDAB] : lane_res[LN_DAB];
        end
      end
      smds_pkg::OP_MOVE: begin
        if (mov) begin
          sel_a_d = SRC_MOV;
        end else if (acrit) begin
          sel_a_d   = SRC_NXA;
          sel_b_d   = SRC_RECIP;
          recip_go  = 1'b1;
          recip_mag = lane_res[LN_XB];
        end else begin
          sel_a_d   = SRC_RECIP;
          recip_go  = 1'b1;
          neg_d     = lane_res[LN_DXB][DW-1];
          recip_mag = neg_d ? lane_res[LN_NDXB] : lane_res[LN_DXB];
        end
      end
      default: begin
        sel_a_d = SRC_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLASSIFY) begin
      sel_a_q <= sel_a_d;
      sel_b_q <= sel_b_d;
      neg_q   <= neg_d;
    end
  end

  assign recip_req.start = (state_q == ST_CLASSIFY) && recip_go;
  assign recip_req.mag   = recip_mag;

  smds_recip u_recip (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (recip_req),
    .rsp_o  (recip_rsp)
  );

  // ------------------------------------------------------- second pass
  function automatic logic [DW-1:0] src_value(src_e s, logic [DW-1:0] v_aov,
                                             logic [DW-1:0] v_bov, logic [DW-1:0] v_da,
                                             logic [DW-1:0] v_db, logic [DW-1:0] v_mov,
                                             logic [DW-1:0] v_nxa,
                                             logic [SCORE_W-1:0] v_q);
    logic [DW-1:0] v;
    case (s)
      SRC_AOV:   v = v_aov;
      SRC_BOV:   v = v_bov;
      SRC_DA:    v = v_da;
      SRC_DB:    v = v_db;
      SRC_MOV:   v = v_mov;
      SRC_NXA:   v = v_nxa;
      SRC_RECIP: v = DW'(v_q);
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign opa_val   = src_value(sel_a_q, lane_res[LN_AOV], lane_res[LN_BOV],
                               lane_res[LN_DA], lane_res[LN_DB], lane_res[LN_MOV],
                               lane_res[LN_NXA], recip_rsp.q);
  assign opb_val   = src_value(sel_b_q, lane_res[LN_AOV], lane_res[LN_BOV],
                               lane_res[LN_DA], lane_res[LN_DB], lane_res[LN_MOV],
                               lane_res[LN_NXA], recip_rsp.q);
  assign inv_a_val = (sel_a_q == SRC_RECIP) && neg_q;
  assign inv_b_val = (sel_b_q == SRC_RECIP) && neg_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD2) begin
      opa_q   <= opa_val;
      opb_q   <= opb_val;
      inv_a_q <= inv_a_val;
      inv_b_q <= inv_b_val;
    end else if (state_q == ST_PASS2) begin
      opa_q <= opa_q >> DIGIT;
      opb_q <= opb_q >> DIGIT;
    end
  end

  assign p2_dig = {opa_q[DIGIT-1:0] ^ {DIGIT{inv_a_q}},
                   opb_q[DIGIT-1:0] ^ {DIGIT{inv_b_q}}, DZ, DZ};
  // carry-in is taken on the load cycle, before the inversion flags register
  assign p2_cin = 2'(inv_a_val) + 2'(inv_b_val);

  smds_lane u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (state_q == ST_LOAD2),
    .shift_i (state_q == ST_PASS2),
    .cin_i   (p2_cin),
    .dig_i   (p2_dig),
    .res_o   (score_sum)
  );

  // ------------------------------------------------------- keep best
  assign fits      = (&score_sum[DW-1:SCORE_W-1]) || (~|score_sum[DW-1:SCORE_W-1]);
  assign sat_score = fits ? score_sum[SCORE_W-1:0]
                          : (score_sum[DW-1] ? smds_pkg::SCORE_MIN : smds_pkg::SCORE_MAX);
  assign take      = !run_open_q || (sat_score < held_score_q);

  assign nxt_kind   = take ? kind_q    : held_kind_q;
  assign nxt_origin = take ? origin_q  : held_origin_q;
  assign nxt_target = take ? target_q  : held_target_q;
  assign nxt_score  = take ? sat_score : held_score_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q    <= 1'b0;
      held_kind_q   <= 1'b0;
      held_origin_q <= '0;
      held_target_q <= '0;
      held_score_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        held_kind_q   <= nxt_kind;
        held_origin_q <= nxt_origin;
        held_target_q <= nxt_target;
        held_score_q  <= nxt_score;
        run_open_q    <= !last_q;
        if (last_q) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && last_q) begin
      out_kind_q   <= nxt_kind;
      out_origin_q <= nxt_origin;
      out_target_q <= nxt_target;
      out_score_q  <= nxt_score;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.best_kind   = out_kind_q;
  assign out_o.best_origin = out_origin_q;
  assign out_o.best_target = out_target_q;
  assign out_o.best_score  = out_score_q;

  // ------------------------------------------------------- checks
  `SMDS_ASSERT(a_accept_starts_pass, clk_i, rst_ni, accept |=> (state_q == ST_PASS1) && (cnt_q == '0), "accepted word did not start the first pass")
  `SMDS_ASSERT_NEVER(a_recip_done_outside_div, clk_i, rst_ni, recip_rsp.done && (state_q != ST_DIV), "reciprocal finished outside its wait state")
  `SMDS_ASSERT(a_last_closes_run, clk_i, rst_ni, (commit && last_q) |=> (!run_open_q && out_valid_q), "last word did not close the run and post the result")

endmodule

// ===== src/smds_lane.sv =====
module smds_lane (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             clear_i,
  input  logic                                             shift_i,
  input  logic [1:0]                                       cin_i,
  input  logic [smds_pkg::LANE_OPS-1:0][smds_pkg::DIGIT-1:0] dig_i,
  output logic [smds_pkg::DW-1:0]                          res_o
);

  logic [1:0]                   carry_q;
  logic [smds_pkg::DW-1:0]      res_q;
  logic [smds_pkg::SUM_W-1:0]   sum;

  always_comb begin
    sum = smds_pkg::SUM_W'(carry_q);
    for (int i = 0; i < smds_pkg::LANE_OPS; i++) begin
      sum = sum + smds_pkg::SUM_W'(dig_i[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else if (clear_i) begin
      carry_q <= cin_i;
    end else if (shift_i) begin
      carry_q <= sum[smds_pkg::SUM_W-1:smds_pkg::DIGIT];
    end
  end

  // result fills from the top, least significant digit first
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      res_q <= {sum[smds_pkg::DIGIT-1:0], res_q[smds_pkg::DW-1:smds_pkg::DIGIT]};
    end
  end

  assign res_o = res_q;

endmodule

// ===== src/smds_recip.sv =====
module smds_recip (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  smds_pkg::recip_req_t  req_i,
  output smds_pkg::recip_rsp_t  rsp_o
);

  logic                              busy_q;
  logic                              done_q;
  logic [smds_pkg::RCNT_W-1:0]       cnt_q;
  logic [smds_pkg::QW-1:0]           m_q;
  logic [smds_pkg::RW-1:0]           rem_q;
  logic [smds_pkg::SCORE_W-1:0]      q_q;
  logic                              mag_zero;
  logic                              mag_big;
  logic [smds_pkg::RW-1:0]           rem_sh;
  logic [smds_pkg::RW-1:0]           diff;
  logic                              fit;

  assign mag_zero = ~|req_i.mag;
  assign mag_big  = (|req_i.mag[smds_pkg::DW-1:smds_pkg::QW]) ||
                    (req_i.mag[smds_pkg::QW-1] && (|req_i.mag[smds_pkg::QW-2:0]));

  // the single dividend bit enters on the first step
  assign rem_sh = {rem_q[smds_pkg::RW-2:0],
                   cnt_q == smds_pkg::RCNT_W'(smds_pkg::RECIP_SHIFT)};
  assign fit    = rem_sh >= {1'b0, m_q};
  assign diff   = rem_sh - {1'b0, m_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        if (mag_zero || mag_big) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= smds_pkg::RCNT_W'(smds_pkg::RECIP_SHIFT);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      m_q   <= req_i.mag[smds_pkg::QW-1:0];
      rem_q <= '0;
      q_q   <= mag_zero ? smds_pkg::SCORE_MAX : '0;
    end else if (busy_q) begin
      rem_q <= fit ? diff : rem_sh;
      q_q   <= {q_q[smds_pkg::SCORE_W-2:0], fit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = q_q;

endmodule
